### rtl/aids_pkg.sv
package aids_pkg;

    // Default geometry of the store
    localparam int DEPTH_DEF     = 64;
    localparam int WORD_BITS_DEF = 32;

    // Index width wide enough for any supported depth and for the 6-bit position field
    localparam int IDXW = 11;

    // Field widths of the stream payloads
    localparam int CMD_W    = 3;
    localparam int POS_W    = 6;
    localparam int VAL_W    = 32;
    localparam int DATA_W   = 32;
    localparam int LEN_W    = 7;
    localparam int STAT_W   = 2;
    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 48;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_APPEND = 3'd1;
    localparam logic [CMD_W-1:0] CMD_READ   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_INSERT = 3'd3;
    localparam logic [CMD_W-1:0] CMD_DELETE = 3'd4;
    localparam logic [CMD_W-1:0] CMD_SORT   = 3'd5;

    // Status codes
    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_RANGE = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;
    localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd3;

    // Operation broadcast to every cell of the row
    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_APPEND,
        CELL_INSERT,
        CELL_DELETE,
        CELL_SORT
    } cell_op_t;

    typedef struct packed {
        cell_op_t        op;
        logic            phase;   // sort pass parity: cells with this index parity lead a pair
        logic [IDXW-1:0] pos;
        logic [IDXW-1:0] count;
    } cell_ctrl_t;

endpackage

### rtl/array_insert_delete_sort.sv
// Bounded store of DEPTH signed words kept in a row of cells, each cell one entry.
// Every input transfer (clear, append, read, insert, delete, sort) returns one result
// transfer with the read word, the length after the command and a status; on an error
// status the store is unchanged. For clear, append, read, insert and delete any change
// to the row is made at once and the result is loaded into the output register. The
// next transfer is taken in the following cycle only if that register is empty or its
// result is taken in the same cycle, so a stalled result stalls the input. Sort runs
// odd-even transposition over the row, one pass per cycle, for as many passes as there
// are valid entries, and holds off input until the last pass is done. Its result is
// loaded at once, like any other command.
module array_insert_delete_sort #(
    parameter int DEPTH     = aids_pkg::DEPTH_DEF,
    parameter int WORD_BITS = aids_pkg::WORD_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [aids_pkg::S_TDATA_W-1:0]  s_tdata,   // command[2:0], position[8:3], value[40:9]
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [aids_pkg::M_TDATA_W-1:0]  m_tdata    // read_data[31:0], length[38:32], status[40:39]
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int AW = $clog2(DEPTH);
    localparam logic [aids_pkg::IDXW-1:0] DEPTH_X = aids_pkg::IDXW'(DEPTH);

    typedef enum logic {
        ST_IDLE,
        ST_SORT
    } state_t;

    // Input fields
    logic [aids_pkg::CMD_W-1:0] command;
    logic [aids_pkg::POS_W-1:0] position;
    logic [aids_pkg::VAL_W-1:0] value;

    assign command  = s_tdata[2:0];
    assign position = s_tdata[8:3];
    assign value    = s_tdata[40:9];

    state_t                      state_reg, state_next;
    logic [CW-1:0]               count_reg, count_next;
    logic [CW-1:0]               pass_reg, pass_next;
    logic                        out_valid_reg, out_valid_next;
    logic [aids_pkg::DATA_W-1:0] out_data_reg, out_data_next;
    logic [aids_pkg::LEN_W-1:0]  out_len_reg, out_len_next;
    logic [aids_pkg::STAT_W-1:0] out_stat_reg, out_stat_next;

    logic                        accept;
    logic [aids_pkg::IDXW-1:0]   cnt_x;
    logic [aids_pkg::IDXW-1:0]   pos_x;
    logic                        full;
    logic                        empty;
    logic [aids_pkg::STAT_W-1:0] stat;
    logic [aids_pkg::DATA_W-1:0] rd_out;
    logic [WORD_BITS-1:0]        rd_word;
    logic [WORD_BITS-1:0]        store_word;
    logic signed [63:0]          val_wide;
    logic signed [63:0]          rd_wide;
    aids_pkg::cell_ctrl_t        ctrl;
    logic [WORD_BITS-1:0]        cell_q [DEPTH];

    assign s_tready = (state_reg == ST_IDLE) && (!out_valid_reg || m_tready);
    assign accept   = s_tvalid && s_tready;

    assign cnt_x = aids_pkg::IDXW'(count_reg);
    assign pos_x = aids_pkg::IDXW'(position);
    assign full  = (cnt_x >= DEPTH_X);
    assign empty = (count_reg == '0);

    // Value sign-extended, then kept at the word width
    assign val_wide   = 64'($signed(value));
    assign store_word = val_wide[WORD_BITS-1:0];

    // Read port: entry selected by position, sign-extended to the result width
    assign rd_word = cell_q[pos_x[AW-1:0]];
    assign rd_wide = 64'($signed(rd_word));

    // Command decode and status
    always_comb
    begin
        stat   = aids_pkg::STAT_OK;
        rd_out = '0;
        unique case (command)
            aids_pkg::CMD_APPEND:
            begin
                if (full)
                    stat = aids_pkg::STAT_FULL;
            end
            aids_pkg::CMD_READ:
            begin
                if (empty)
                    stat = aids_pkg::STAT_EMPTY;
                else if (pos_x >= cnt_x)
                    stat = aids_pkg::STAT_RANGE;
                else
                    rd_out = rd_wide[aids_pkg::DATA_W-1:0];
            end
            aids_pkg::CMD_INSERT:
            begin
                if (full)
                    stat = aids_pkg::STAT_FULL;
                else if (pos_x > cnt_x)
                    stat = aids_pkg::STAT_RANGE;
            end
            aids_pkg::CMD_DELETE:
            begin
                if (empty)
                    stat = aids_pkg::STAT_EMPTY;
                else if (pos_x >= cnt_x)
                    stat = aids_pkg::STAT_RANGE;
            end
            aids_pkg::CMD_SORT:
            begin
                if (empty)
                    stat = aids_pkg::STAT_EMPTY;
            end
            default:
            begin
                stat = aids_pkg::STAT_OK;
            end
        endcase
    end

    // Sequencer, length count and result register
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        pass_next      = pass_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        out_len_next   = out_len_reg;
        out_stat_next  = out_stat_reg;
        ctrl.op        = aids_pkg::CELL_HOLD;
        ctrl.phase     = pass_reg[0];
        ctrl.pos       = pos_x;
        ctrl.count     = cnt_x;

        if (out_valid_reg && m_tready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (stat == aids_pkg::STAT_OK)
                    begin
                        case (command)
                            aids_pkg::CMD_CLEAR:
                            begin
                                count_next = '0;
                            end
                            aids_pkg::CMD_APPEND:
                            begin
                                ctrl.op    = aids_pkg::CELL_APPEND;
                                count_next = count_reg + CW'(1);
                            end
                            aids_pkg::CMD_INSERT:
                            begin
                                ctrl.op    = aids_pkg::CELL_INSERT;
                                count_next = count_reg + CW'(1);
                            end
                            aids_pkg::CMD_DELETE:
                            begin
                                ctrl.op    = aids_pkg::CELL_DELETE;
                                count_next = count_reg - CW'(1);
                            end
                            aids_pkg::CMD_SORT:
                            begin
                                pass_next  = '0;
                                state_next = ST_SORT;
                            end
                            default:
                            begin
                                count_next = count_reg;
                            end
                        endcase
                    end
                    out_valid_next = 1'b1;
                    out_data_next  = rd_out;
                    out_len_next   = aids_pkg::LEN_W'(count_next);
                    out_stat_next  = stat;
                end
            end
            ST_SORT:
            begin
                ctrl.op   = aids_pkg::CELL_SORT;
                pass_next = pass_reg + CW'(1);
                if (pass_reg == count_reg - CW'(1))
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            pass_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            pass_reg      <= pass_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        out_len_reg  <= out_len_next;
        out_stat_reg <= out_stat_next;
    end

    // Row of cells, each linked to both neighbors
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [WORD_BITS-1:0] left_w;
        logic [WORD_BITS-1:0] right_w;

        if (i == 0)
        begin : g_first
            assign left_w = '0;
        end
        else
        begin : g_left
            assign left_w = cell_q[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign right_w = '0;
        end
        else
        begin : g_right
            assign right_w = cell_q[i+1];
        end

        aids_cell #(
            .IDX       (i),
            .WORD_BITS (WORD_BITS)
        ) u_cell (
            .clk   (clk),
            .ctrl  (ctrl),
            .value (store_word),
            .left  (left_w),
            .right (right_w),
            .q     (cell_q[i])
        );
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_stat_reg, out_len_reg, out_data_reg};

    // Length never passes the store depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        aids_pkg::IDXW'(count_reg) <= DEPTH_X)
        else $error("length count beyond depth");

    // Every accepted transfer leaves a result in the output register
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> out_valid_reg)
        else $error("accepted transfer without result");

    // A full-store status is only reported at full length
    a_full_len: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_stat_reg == aids_pkg::STAT_FULL)) |->
        (aids_pkg::IDXW'(out_len_reg) == (DEPTH_X & aids_pkg::IDXW'(7'h7f))))
        else $error("full status with short length");

    // No new transfer is taken while a sort is running
    a_sort_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SORT) |-> !s_tready)
        else $error("input taken during sort");

endmodule

### rtl/aids_cell.sv
module aids_cell #(
    parameter int IDX       = 0,
    parameter int WORD_BITS = aids_pkg::WORD_BITS_DEF
) (
    input  logic                 clk,
    input  aids_pkg::cell_ctrl_t ctrl,
    input  logic [WORD_BITS-1:0] value,
    input  logic [WORD_BITS-1:0] left,   // word of the cell below
    input  logic [WORD_BITS-1:0] right,  // word of the cell above
    output logic [WORD_BITS-1:0] q
);

    localparam logic [aids_pkg::IDXW-1:0] MY    = aids_pkg::IDXW'(IDX);
    localparam logic [aids_pkg::IDXW-1:0] MY_UP = aids_pkg::IDXW'(IDX + 1);

    logic [WORD_BITS-1:0] q_reg;
    logic [WORD_BITS-1:0] q_next;
    logic                 own_valid;
    logic                 up_valid;
    logic                 lead;

    assign own_valid = (MY < ctrl.count);
    assign up_valid  = (MY_UP < ctrl.count);
    assign lead      = (MY[0] == ctrl.phase);

    // Next word: load, shift from a neighbor, or compare-exchange with the pair partner
    always_comb
    begin
        q_next = q_reg;
        case (ctrl.op)
            aids_pkg::CELL_APPEND:
            begin
                if (MY == ctrl.count)
                    q_next = value;
            end
            aids_pkg::CELL_INSERT:
            begin
                if (MY == ctrl.pos)
                    q_next = value;
                else if (MY > ctrl.pos)
                    q_next = left;
            end
            aids_pkg::CELL_DELETE:
            begin
                if (MY >= ctrl.pos)
                    q_next = right;
            end
            aids_pkg::CELL_SORT:
            begin
                // larger value moves toward index zero
                if (lead)
                begin
                    if (up_valid && ($signed(q_reg) < $signed(right)))
                        q_next = right;
                end
                else
                begin
                    if ((MY != '0) && own_valid && ($signed(left) < $signed(q_reg)))
                        q_next = left;
                end
            end
            default:
            begin
                q_next = q_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
    end

    assign q = q_reg;

endmodule

### verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    // Unused command codes: the block answers them with status ok and no change
    localparam logic [aids_pkg::CMD_W-1:0] CMD_SPARE_A = 3'd6;
    localparam logic [aids_pkg::CMD_W-1:0] CMD_SPARE_B = 3'd7;

    localparam int STORE_DEPTH = aids_pkg::DEPTH_DEF;
    localparam int LONG_HOLD   = 200;
    localparam int TAIL_CYCLES = 150;
    localparam int MAX_PRINTS  = 40;

    typedef struct {
        logic [aids_pkg::DATA_W-1:0] read_data;
        logic [aids_pkg::LEN_W-1:0]  length;
        logic [aids_pkg::STAT_W-1:0] status;
    } array_result_t;

    logic                           clk      = 1'b0;
    logic                           rst_n    = 1'b0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [aids_pkg::S_TDATA_W-1:0] s_tdata  = '0;
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [aids_pkg::M_TDATA_W-1:0] m_tdata;

    // Shadow copy of the store
    logic signed [aids_pkg::DATA_W-1:0] shadow_mem [0:STORE_DEPTH-1];
    int                                 fill_count = 0;

    array_result_t pending_results[$];
    int            error_count   = 0;
    bit            src_idle_on   = 1'b1;
    bit            sink_idle_on  = 1'b1;
    bit            hold_request  = 1'b0;
    bit            growing       = 1'b1;

    array_insert_delete_sort uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Clock
    initial
    begin
        forever #5 clk = ~clk;
    end

    // Run limit
    initial
    begin
        #5_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    // Descending order by signed value, insertion style
    function automatic void sort_shadow_descending();
        logic signed [aids_pkg::DATA_W-1:0] cur;
        int j;
        for (int i = 1; i < fill_count; i++)
        begin
            cur = shadow_mem[i];
            j = i;
            while (j > 0 && shadow_mem[j-1] < cur)
            begin
                shadow_mem[j] = shadow_mem[j-1];
                j--;
            end
            shadow_mem[j] = cur;
        end
    endfunction

    // Apply one command to the shadow store and queue the result it should give
    function automatic void predict_array_op(logic [aids_pkg::CMD_W-1:0] cmd,
                                             logic [aids_pkg::POS_W-1:0] pos,
                                             logic [aids_pkg::VAL_W-1:0] val);
        array_result_t res;
        int p;
        p = pos;
        res.read_data = '0;
        res.status    = aids_pkg::STAT_OK;
        case (cmd)
            aids_pkg::CMD_CLEAR:
                fill_count = 0;
            aids_pkg::CMD_APPEND:
                if (fill_count >= STORE_DEPTH)
                    res.status = aids_pkg::STAT_FULL;
                else
                begin
                    shadow_mem[fill_count] = val;
                    fill_count++;
                end
            aids_pkg::CMD_READ:
                if (fill_count == 0)
                    res.status = aids_pkg::STAT_EMPTY;
                else if (p >= fill_count)
                    res.status = aids_pkg::STAT_RANGE;
                else
                    res.read_data = shadow_mem[p];
            aids_pkg::CMD_INSERT:
                if (fill_count >= STORE_DEPTH)
                    res.status = aids_pkg::STAT_FULL;
                else if (p > fill_count)
                    res.status = aids_pkg::STAT_RANGE;
                else
                begin
                    for (int i = fill_count; i > p; i--)
                        shadow_mem[i] = shadow_mem[i-1];
                    shadow_mem[p] = val;
                    fill_count++;
                end
            aids_pkg::CMD_DELETE:
                if (fill_count == 0)
                    res.status = aids_pkg::STAT_EMPTY;
                else if (p >= fill_count)
                    res.status = aids_pkg::STAT_RANGE;
                else
                begin
                    for (int i = p; i + 1 < fill_count; i++)
                        shadow_mem[i] = shadow_mem[i+1];
                    fill_count--;
                end
            aids_pkg::CMD_SORT:
                if (fill_count == 0)
                    res.status = aids_pkg::STAT_EMPTY;
                else
                    sort_shadow_descending();
            default:
                ;
        endcase
        res.length = fill_count[aids_pkg::LEN_W-1:0];
        pending_results.push_back(res);
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        if (error_count < MAX_PRINTS)
            $display("%0t mismatch %s: got %0h expected %0h", $realtime, what, got, want);
        error_count++;
    endtask

    // Compare one result transfer with the oldest expectation
    task automatic check_result(input logic [aids_pkg::M_TDATA_W-1:0] word);
        array_result_t want;
        logic [aids_pkg::DATA_W-1:0] got_data;
        logic [aids_pkg::LEN_W-1:0]  got_len;
        logic [aids_pkg::STAT_W-1:0] got_stat;
        got_data = word[aids_pkg::DATA_W-1:0];
        got_len  = word[aids_pkg::DATA_W+aids_pkg::LEN_W-1:aids_pkg::DATA_W];
        got_stat = word[aids_pkg::DATA_W+aids_pkg::LEN_W+aids_pkg::STAT_W-1:
                        aids_pkg::DATA_W+aids_pkg::LEN_W];
        if (pending_results.size() == 0)
        begin
            report_mismatch("unexpected result", 64'(word), 64'd0);
            return;
        end
        want = pending_results.pop_front();
        if (got_data !== want.read_data)
            report_mismatch("read_data", 64'(got_data), 64'(want.read_data));
        if (got_len !== want.length)
            report_mismatch("length", 64'(got_len), 64'(want.length));
        if (got_stat !== want.status)
            report_mismatch("status", 64'(got_stat), 64'(want.status));
    endtask

    // Receiver: checks every result transfer, idles in bursts, long hold on request
    initial
    begin
        int gap_left;
        gap_left = 0;
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
                check_result(m_tdata);
            if (hold_request)
            begin
                hold_request = 1'b0;
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            else if (gap_left > 0)
            begin
                m_tready <= 1'b0;
                gap_left--;
            end
            else if (sink_idle_on && $urandom_range(0, 7) == 0)
            begin
                m_tready <= 1'b0;
                gap_left = $urandom_range(1, 8) - 1;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // Offer one command and wait for its transfer; entered and left at a rising edge
    task automatic send_item(input logic [aids_pkg::CMD_W-1:0] cmd,
                             input logic [aids_pkg::POS_W-1:0] pos,
                             input logic [aids_pkg::VAL_W-1:0] val);
        if (src_idle_on && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(aids_pkg::S_TDATA_W-aids_pkg::CMD_W-aids_pkg::POS_W-aids_pkg::VAL_W){1'b0}},
                     val, pos, cmd};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predict_array_op(cmd, pos, val);
    endtask

    // Mix of small values (duplicates for sort), extremes and full-range words
    function automatic logic [aids_pkg::VAL_W-1:0] rand_value();
        logic [aids_pkg::VAL_W-1:0] v;
        case ($urandom_range(0, 3))
            0: v = 32'($urandom_range(0, 7)) - 32'd4;
            1:
                case ($urandom_range(0, 3))
                    0: v = 32'h7FFF_FFFF;
                    1: v = 32'h8000_0000;
                    2: v = 32'h0000_0000;
                    default: v = 32'hFFFF_FFFF;
                endcase
            default: v = $urandom;
        endcase
        return v;
    endfunction

    // Position mostly inside the valid range, sometimes anywhere
    function automatic logic [aids_pkg::POS_W-1:0] rand_pos(int top);
        int hi;
        hi = (top > STORE_DEPTH - 1) ? STORE_DEPTH - 1 : top;
        if (hi >= 0 && $urandom_range(0, 9) < 8)
            return aids_pkg::POS_W'($urandom_range(0, hi));
        return aids_pkg::POS_W'($urandom_range(0, STORE_DEPTH - 1));
    endfunction

    // One random command; the mix drifts the length up to full and back down to empty
    task automatic send_random_op();
        int r;
        logic [aids_pkg::CMD_W-1:0] cmd;
        logic [aids_pkg::POS_W-1:0] pos;
        if (fill_count >= STORE_DEPTH)
            growing = 1'b0;
        else if (fill_count == 0)
            growing = 1'b1;
        else if ($urandom_range(0, 39) == 0)
            growing = ~growing;
        r = $urandom_range(0, 99);
        if (r < (growing ? 35 : 8))
            cmd = aids_pkg::CMD_APPEND;
        else if (r < (growing ? 55 : 18))
            cmd = aids_pkg::CMD_INSERT;
        else if (r < (growing ? 70 : 40))
            cmd = aids_pkg::CMD_READ;
        else if (r < 82)
            cmd = aids_pkg::CMD_DELETE;
        else if (r < 87)
            cmd = aids_pkg::CMD_SORT;
        else if (r < 88)
            cmd = aids_pkg::CMD_CLEAR;
        else if (r < 91)
            cmd = ($urandom_range(0, 1) == 0) ? CMD_SPARE_A : CMD_SPARE_B;
        else
            cmd = aids_pkg::CMD_W'($urandom_range(0, 7));
        if (r >= 91)
            pos = aids_pkg::POS_W'($urandom_range(0, STORE_DEPTH - 1));
        else if (cmd == aids_pkg::CMD_INSERT)
            pos = rand_pos(fill_count);
        else
            pos = rand_pos(fill_count - 1);
        send_item(cmd, pos, rand_value());
    endtask

    // Empty-store errors, range edges, extreme words, spare codes, sort and clear
    task automatic test_directed();
        send_item(aids_pkg::CMD_READ,   6'd0,  32'h0);
        send_item(aids_pkg::CMD_DELETE, 6'd0,  32'h0);
        send_item(aids_pkg::CMD_SORT,   6'd0,  32'h0);
        send_item(aids_pkg::CMD_INSERT, 6'd1,  32'h5);
        send_item(aids_pkg::CMD_INSERT, 6'd0,  32'h7FFF_FFFF);
        send_item(aids_pkg::CMD_APPEND, 6'd63, 32'h8000_0000);
        send_item(aids_pkg::CMD_INSERT, 6'd2,  32'h0);
        send_item(aids_pkg::CMD_INSERT, 6'd1,  32'hFFFF_FFFF);
        send_item(aids_pkg::CMD_INSERT, 6'd5,  32'h1);
        send_item(aids_pkg::CMD_READ,   6'd3,  32'h0);
        send_item(aids_pkg::CMD_READ,   6'd4,  32'h0);
        send_item(aids_pkg::CMD_READ,   6'd63, 32'hFFFF_FFFF);
        send_item(aids_pkg::CMD_SORT,   6'd0,  32'h0);
        for (int i = 0; i < 4; i++)
            send_item(aids_pkg::CMD_READ, aids_pkg::POS_W'(i), 32'h0);
        send_item(aids_pkg::CMD_DELETE, 6'd63, 32'h0);
        send_item(aids_pkg::CMD_DELETE, 6'd3,  32'h0);
        send_item(aids_pkg::CMD_DELETE, 6'd0,  32'h0);
        send_item(CMD_SPARE_A, 6'd63, 32'hFFFF_FFFF);
        send_item(CMD_SPARE_B, 6'd21, 32'h5555_5555);
        send_item(aids_pkg::CMD_APPEND, 6'd0,  32'h1);
        send_item(aids_pkg::CMD_SORT,   6'd0,  32'h0);
        send_item(aids_pkg::CMD_READ,   6'd0,  32'h0);
        send_item(aids_pkg::CMD_CLEAR,  6'd0,  32'h0);
        send_item(aids_pkg::CMD_READ,   6'd0,  32'h0);
    endtask

    // Fill to capacity, then hit the full-store cases and sort a full row
    task automatic test_full_store();
        send_item(aids_pkg::CMD_CLEAR, 6'd0, 32'h0);
        for (int i = 0; i < STORE_DEPTH; i++)
        begin
            if (i > 0 && $urandom_range(0, 2) == 0)
                send_item(aids_pkg::CMD_INSERT, aids_pkg::POS_W'($urandom_range(0, i)),
                          rand_value());
            else
                send_item(aids_pkg::CMD_APPEND, aids_pkg::POS_W'($urandom_range(0, 63)),
                          rand_value());
        end
        send_item(aids_pkg::CMD_APPEND, 6'd0,  rand_value());
        send_item(aids_pkg::CMD_INSERT, 6'd0,  rand_value());
        send_item(aids_pkg::CMD_INSERT, 6'd63, rand_value());
        send_item(aids_pkg::CMD_READ,   6'd63, 32'h0);
        send_item(aids_pkg::CMD_SORT,   6'd0,  32'h0);
        send_item(aids_pkg::CMD_READ,   6'd0,  32'h0);
        send_item(aids_pkg::CMD_READ,   6'd63, 32'h0);
        send_item(aids_pkg::CMD_DELETE, 6'd63, 32'h0);
        send_item(aids_pkg::CMD_INSERT, 6'd63, rand_value());
        send_item(aids_pkg::CMD_APPEND, 6'd0,  rand_value());
        send_item(aids_pkg::CMD_DELETE, 6'd0,  32'h0);
        send_item(aids_pkg::CMD_READ,   6'd0,  32'h0);
    endtask

    task automatic test_random(input int n);
        for (int i = 0; i < n; i++)
            send_random_op();
    endtask

    // Receiver holds off for a long stretch while commands keep coming
    task automatic test_backpressure();
        hold_request = 1'b1;
        for (int i = 0; i < 12; i++)
            send_random_op();
    endtask

    // Sender stops until every outstanding result is back, then resumes
    task automatic test_drain_pause();
        for (int i = 0; i < 10; i++)
            send_random_op();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (pending_results.size() != 0);
        for (int i = 0; i < 10; i++)
            send_random_op();
    endtask

    // Back-to-back transfers with both sides always ready
    task automatic test_streaming(input int n);
        src_idle_on  = 1'b0;
        sink_idle_on = 1'b0;
        for (int i = 0; i < n; i++)
            send_random_op();
    endtask

    // Test sequence
    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_full_store();
        test_random(400);
        test_backpressure();
        test_drain_pause();
        test_streaming(60);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (error_count == 0 && pending_results.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
